@@ hdl/mptt_pkg.sv @@
package mptt_pkg;

  localparam int MaxTimersDefault = 16;
  localparam int KeyW = 16;
  localparam int TimeW = 32;

  typedef enum logic [1:0] {
    OP_ADVANCE = 2'd0,
    OP_ADD     = 2'd1,
    OP_CHANGE  = 2'd2,
    OP_REMOVE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef struct packed {
    logic             start;
    logic [TimeW-1:0] dividend;
    logic [TimeW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [TimeW-1:0] quotient;
    logic [TimeW-1:0] remainder;
  } div_rsp_t;

endpackage

@@ hdl/multi_periodic_timer_table_core.sv @@
// Channel   Direction  Handshake        Fields
// command   in         start / busy     op, timer_key, period_us, elapsed_us
// result    out        strobe           fired_key, fire_count, status, last_result
//
// Add, and change or remove on an empty table, answer in the cycle after the transaction
// and leave busy low. Change and remove read and compare one entry at a time in S_READ and
// S_SCAN, and a remove then moves the last entry into the freed slot in S_MOVE.
// Advance walks each entry through S_READ, S_EVAL and S_WRITE; an entry that expires with a
// nonzero period also waits in S_DIV on the shared 32-step restoring divider.
// Reset empties the table at once. The receiver cannot stall; busy holds off commands.
module multi_periodic_timer_table_core #(
  parameter int MAX_TIMERS = mptt_pkg::MaxTimersDefault
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 op,
  input  logic [mptt_pkg::KeyW-1:0]  timer_key,
  input  logic [mptt_pkg::TimeW-1:0] period_us,
  input  logic [mptt_pkg::TimeW-1:0] elapsed_us,
  output logic                       strobe,
  output logic [mptt_pkg::KeyW-1:0]  fired_key,
  output logic [mptt_pkg::TimeW-1:0] fire_count,
  output logic [1:0]                 status,
  output logic                       last_result
);
  import mptt_pkg::*;

  localparam int IdxW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int CntW = $clog2(MAX_TIMERS + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_EVAL, S_DIV, S_WRITE, S_SCAN, S_MOVE
  } state_t;

  state_t state;
  logic [KeyW-1:0]  mem_key  [MAX_TIMERS];
  logic [TimeW-1:0] mem_per  [MAX_TIMERS];
  logic [TimeW-1:0] mem_left [MAX_TIMERS];

  logic [CntW-1:0]  count;
  logic [CntW-1:0]  ptr;
  logic [1:0]       cmd_op;
  logic [KeyW-1:0]  cmd_key;
  logic [TimeW-1:0] cmd_per;
  logic [TimeW-1:0] cmd_dt;
  logic [KeyW-1:0]  rd_key;
  logic [TimeW-1:0] rd_per;
  logic [TimeW-1:0] rd_left;
  logic [IdxW-1:0]  hit;
  logic [IdxW-1:0]  rd_addr;
  logic             div_wait;
  div_req_t         dreq;
  div_rsp_t         drsp;

  logic [IdxW-1:0] ptr_idx;
  logic [IdxW-1:0] last_idx;
  logic            last_ent;
  assign ptr_idx = ptr[IdxW-1:0];
  assign last_idx = IdxW'(count - 1'b1);
  assign last_ent = (ptr + 1'b1) == count;

  mptt_divider u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  assign dreq.start = (state == S_EVAL) && (rd_per != '0) && (cmd_dt >= rd_left);
  assign dreq.dividend = cmd_dt - rd_left;
  assign dreq.divisor = rd_per;

  always_ff @(posedge clk) begin
    rd_key  <= mem_key[rd_addr];
    rd_per  <= mem_per[rd_addr];
    rd_left <= mem_left[rd_addr];
  end

  always_comb begin
    rd_addr = ptr_idx;
    if (state == S_MOVE) rd_addr = last_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      strobe <= 1'b0;
      div_wait <= 1'b0;
      ptr <= '0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cmd_op <= op;
            cmd_key <= timer_key;
            cmd_per <= period_us;
            cmd_dt <= elapsed_us;
            ptr <= '0;
            unique case (op_t'(op))
              OP_ADVANCE: if (count != '0) state <= S_READ;
              OP_ADD: begin
                strobe <= 1'b1;
                fired_key <= timer_key;
                fire_count <= '0;
                last_result <= 1'b1;
                if (count == CntW'(MAX_TIMERS)) begin
                  status <= ST_FULL;
                end else begin
                  status <= ST_OK;
                  mem_key[IdxW'(count)] <= timer_key;
                  mem_per[IdxW'(count)] <= period_us;
                  mem_left[IdxW'(count)] <= period_us;
                  count <= count + 1'b1;
                end
              end
              default: begin
                if (count == '0) begin
                  strobe <= 1'b1;
                  fired_key <= timer_key;
                  fire_count <= '0;
                  status <= ST_NOT_FOUND;
                  last_result <= 1'b1;
                end else begin
                  state <= S_READ;
                end
              end
            endcase
          end
        end
        S_READ: state <= (op_t'(cmd_op) == OP_ADVANCE) ? S_EVAL : S_SCAN;
        S_EVAL: begin
          fired_key <= rd_key;
          status <= ST_OK;
          last_result <= last_ent;
          if (rd_per == '0) begin
            fire_count <= TimeW'(1);
            state <= S_WRITE;
          end else if (cmd_dt >= rd_left) begin
            state <= S_DIV;
          end else begin
            fire_count <= '0;
            mem_left[ptr_idx] <= rd_left - cmd_dt;
            state <= S_WRITE;
          end
        end
        S_DIV: begin
          if (drsp.done) begin
            fire_count <= (drsp.quotient == '1) ? '1 : drsp.quotient + 1'b1;
            mem_left[ptr_idx] <= rd_per - drsp.remainder;
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          strobe <= 1'b1;
          ptr <= ptr + 1'b1;
          state <= last_ent ? S_IDLE : S_READ;
        end
        S_SCAN: begin
          if (rd_key == cmd_key) begin
            hit <= ptr_idx;
            if (op_t'(cmd_op) == OP_CHANGE) begin
              mem_per[ptr_idx] <= cmd_per;
              strobe <= 1'b1;
              fired_key <= cmd_key;
              fire_count <= '0;
              status <= ST_OK;
              last_result <= 1'b1;
              state <= S_IDLE;
            end else begin
              state <= S_MOVE;
              div_wait <= 1'b1;
            end
          end else if (last_ent) begin
            strobe <= 1'b1;
            fired_key <= cmd_key;
            fire_count <= '0;
            status <= ST_NOT_FOUND;
            last_result <= 1'b1;
            state <= S_IDLE;
          end else begin
            ptr <= ptr + 1'b1;
            state <= S_READ;
          end
        end
        S_MOVE: begin
          if (div_wait) begin
            div_wait <= 1'b0;
          end else begin
            mem_key[hit] <= rd_key;
            mem_per[hit] <= rd_per;
            mem_left[hit] <= rd_left;
            count <= count - 1'b1;
            strobe <= 1'b1;
            fired_key <= cmd_key;
            fire_count <= '0;
            status <= ST_OK;
            last_result <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy = (state != S_IDLE);

  property p_count_range;
    @(posedge clk) disable iff (rst) count <= CntW'(MAX_TIMERS);
  endproperty
  a_count_range: assert property (p_count_range) else $error("count overflow");

  property p_walk_in_range;
    @(posedge clk) disable iff (rst) (state == S_EVAL || state == S_SCAN) |-> ptr < count;
  endproperty
  a_walk_in_range: assert property (p_walk_in_range) else $error("walk past end");

  property p_idle_strobe_last;
    @(posedge clk) disable iff (rst) (strobe && state == S_IDLE) |-> last_result;
  endproperty
  a_idle_strobe_last: assert property (p_idle_strobe_last) else $error("missing last");

endmodule

@@ hdl/mptt_divider.sv @@
module mptt_divider (
  input  logic              clk,
  input  logic              rst,
  input  mptt_pkg::div_req_t req,
  output mptt_pkg::div_rsp_t rsp
);
  import mptt_pkg::*;

  localparam int CntW = $clog2(TimeW + 1);

  logic [TimeW-1:0] quo;
  logic [TimeW-1:0] rem;
  logic [TimeW-1:0] dvs;
  logic [CntW-1:0]  cnt;
  logic             running;
  logic             done;
  logic [TimeW:0]   trial;
  logic [TimeW:0]   shifted;

  assign shifted = {rem, quo[TimeW-1]};
  assign trial = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        running <= 1'b1;
        quo <= req.dividend;
        rem <= '0;
        dvs <= req.divisor;
        cnt <= CntW'(TimeW);
      end else if (running) begin
        if (!trial[TimeW]) begin
          rem <= trial[TimeW-1:0];
          quo <= {quo[TimeW-2:0], 1'b1};
        end else begin
          rem <= shifted[TimeW-1:0];
          quo <= {quo[TimeW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          running <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quotient = quo;
  assign rsp.remainder = rem;

  property p_done_after_run;
    @(posedge clk) disable iff (rst) rsp.done |-> $past(running);
  endproperty
  a_done_after_run: assert property (p_done_after_run) else $error("done without run");

  property p_count_bounded;
    @(posedge clk) disable iff (rst) running |-> (cnt != '0);
  endproperty
  a_count_bounded: assert property (p_count_bounded) else $error("counter ran out");

  property p_start_restarts;
    @(posedge clk) disable iff (rst) req.start |=> (running && cnt == CntW'(TimeW));
  endproperty
  a_start_restarts: assert property (p_start_restarts) else $error("start lost");

endmodule
